/* rtl/u2j_pkg.sv */
`default_nettype none

package u2j_pkg;

    localparam int unsigned MaxBytes = 9;
    localparam int unsigned CountW   = 4;

    // Characters that take a short two-byte escape.
    localparam logic [15:0] C_QUOTE  = 16'h0022;
    localparam logic [15:0] C_BSLASH = 16'h005C;
    localparam logic [15:0] C_BSPACE = 16'h0008;
    localparam logic [15:0] C_FFEED  = 16'h000C;
    localparam logic [15:0] C_NLINE  = 16'h000A;
    localparam logic [15:0] C_CRET   = 16'h000D;
    localparam logic [15:0] C_TAB    = 16'h0009;

    localparam logic [7:0] B_BSLASH = 8'h5C;
    localparam logic [7:0] B_U      = 8'h75;
    localparam logic [7:0] B_ZERO   = 8'h30;
    localparam logic [7:0] B_ONE    = 8'h31;

    // U+FFFD encodes as EF BF BD.
    localparam logic [7:0] B_REPL0 = 8'hEF;
    localparam logic [7:0] B_REPL1 = 8'hBF;
    localparam logic [7:0] B_REPL2 = 8'hBD;

    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;

    typedef logic [MaxBytes-1:0][7:0] t_bytes;

    // One encoded code unit: the bytes in order from index 0.
    typedef struct packed {
        t_bytes              bytes;
        logic [CountW-1:0]   count;
        logic                slast;
    } t_enc;

    // Surrogate state carried from one code unit to the next.
    typedef struct packed {
        logic       pend;
        logic [9:0] hbits;
    } t_surr;

endpackage

`default_nettype wire

/* rtl/u2j_if.sv */
`default_nettype none

interface u2j_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        string_last;

    modport source (output valid, output code_unit, output string_last, input ready);
    modport sink   (input valid, input code_unit, input string_last, output ready);
endinterface

interface u2j_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    output ready);
endinterface

`default_nettype wire

/* rtl/u2j_encoder.sv */
`default_nettype none

module u2j_encoder (
    input  wire logic [15:0]   i_unit,
    input  wire logic          i_last,
    input  wire u2j_pkg::t_surr i_surr,
    output u2j_pkg::t_enc      o_enc,
    output u2j_pkg::t_surr     o_surr
);

    logic              is_high;
    logic              is_low;
    logic [7:0]        esc;
    logic [5:0][7:0]   h_bytes;
    logic [2:0]        h_cnt;
    logic [20:0]       cp;
    logic [3:0]        nib;
    logic [7:0]        hex_lo;

    assign is_high = (i_unit[15:10] == u2j_pkg::SURR_HIGH);
    assign is_low  = (i_unit[15:10] == u2j_pkg::SURR_LOW);
    assign nib     = i_unit[3:0];
    assign hex_lo  = (nib < 4'd10) ? {4'h3, nib} : (8'h57 + {4'h0, nib});
    assign cp      = 21'h010000 + {1'b0, i_surr.hbits, i_unit[9:0]};

    always_comb begin
        case (i_unit)
            u2j_pkg::C_QUOTE:  esc = 8'h22;
            u2j_pkg::C_BSLASH: esc = 8'h5C;
            u2j_pkg::C_BSPACE: esc = 8'h62;
            u2j_pkg::C_FFEED:  esc = 8'h66;
            u2j_pkg::C_NLINE:  esc = 8'h6E;
            u2j_pkg::C_CRET:   esc = 8'h72;
            u2j_pkg::C_TAB:    esc = 8'h74;
            default:           esc = 8'h00;
        endcase
    end

    // Bytes for the unit on its own, without any held surrogate.
    always_comb begin
        h_bytes = '0;
        h_cnt   = 3'd0;
        if (esc != 8'h00) begin
            h_bytes[0] = u2j_pkg::B_BSLASH;
            h_bytes[1] = esc;
            h_cnt      = 3'd2;
        end else if (i_unit <= 16'h001F) begin
            h_bytes[0] = u2j_pkg::B_BSLASH;
            h_bytes[1] = u2j_pkg::B_U;
            h_bytes[2] = u2j_pkg::B_ZERO;
            h_bytes[3] = u2j_pkg::B_ZERO;
            h_bytes[4] = i_unit[4] ? u2j_pkg::B_ONE : u2j_pkg::B_ZERO;
            h_bytes[5] = hex_lo;
            h_cnt      = 3'd6;
        end else if ((is_high && i_last) || is_low) begin
            h_bytes[0] = u2j_pkg::B_REPL0;
            h_bytes[1] = u2j_pkg::B_REPL1;
            h_bytes[2] = u2j_pkg::B_REPL2;
            h_cnt      = 3'd3;
        end else if (is_high) begin
            h_cnt = 3'd0;
        end else if (i_unit <= 16'h007F) begin
            h_bytes[0] = i_unit[7:0];
            h_cnt      = 3'd1;
        end else if (i_unit <= 16'h07FF) begin
            h_bytes[0] = {3'b110, i_unit[10:6]};
            h_bytes[1] = {2'b10, i_unit[5:0]};
            h_cnt      = 3'd2;
        end else begin
            h_bytes[0] = {4'b1110, i_unit[15:12]};
            h_bytes[1] = {2'b10, i_unit[11:6]};
            h_bytes[2] = {2'b10, i_unit[5:0]};
            h_cnt      = 3'd3;
        end
    end

    always_comb begin
        o_enc.bytes = '0;
        o_enc.count = '0;
        o_enc.slast = i_last;
        if (i_surr.pend && is_low) begin
            o_enc.bytes[0] = {5'b11110, cp[20:18]};
            o_enc.bytes[1] = {2'b10, cp[17:12]};
            o_enc.bytes[2] = {2'b10, cp[11:6]};
            o_enc.bytes[3] = {2'b10, cp[5:0]};
            o_enc.count    = 4'd4;
        end else if (i_surr.pend) begin
            o_enc.bytes[0]   = u2j_pkg::B_REPL0;
            o_enc.bytes[1]   = u2j_pkg::B_REPL1;
            o_enc.bytes[2]   = u2j_pkg::B_REPL2;
            o_enc.bytes[8:3] = h_bytes;
            o_enc.count      = 4'(h_cnt) + 4'd3;
        end else begin
            o_enc.bytes[5:0] = h_bytes;
            o_enc.count      = 4'(h_cnt);
        end
    end

    // A high surrogate is only held when the string goes on.
    assign o_surr.pend  = is_high && !i_last;
    assign o_surr.hbits = i_unit[9:0];

endmodule

`default_nettype wire

/* rtl/u2j_serializer.sv */
`default_nettype none

module u2j_serializer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire u2j_pkg::t_enc i_enc,
    output logic               o_can_load,
    u2j_byte_if.source         o_byte
);

    u2j_pkg::t_bytes                r_buf;
    u2j_pkg::t_bytes                n_buf;
    logic [u2j_pkg::CountW-1:0]     r_rem;
    logic [u2j_pkg::CountW-1:0]     n_rem;
    logic                           r_slast;
    logic                           n_slast;
    logic                           take;

    assign take       = o_byte.valid && o_byte.ready;
    assign o_can_load = (r_rem == '0) || ((r_rem == 4'd1) && o_byte.ready);

    always_comb begin
        n_buf   = r_buf;
        n_rem   = r_rem;
        n_slast = r_slast;
        if (i_load) begin
            n_buf   = i_enc.bytes;
            n_rem   = i_enc.count;
            n_slast = i_enc.slast;
        end else if (take) begin
            n_buf[u2j_pkg::MaxBytes-2:0] = r_buf[u2j_pkg::MaxBytes-1:1];
            n_rem                        = r_rem - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf   <= n_buf;
        r_slast <= n_slast;
    end

    assign o_byte.valid      = (r_rem != '0);
    assign o_byte.out_byte   = r_buf[0];
    assign o_byte.run_last   = (r_rem == 4'd1);
    assign o_byte.string_end = (r_rem == 4'd1) && r_slast;

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= 4'(u2j_pkg::MaxBytes))
        else $error("byte count exceeds the largest expansion");
    a_more_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !o_byte.run_last) |=> o_byte.valid)
        else $error("run ended before its last byte");
`endif

endmodule

`default_nettype wire

/* rtl/utf16_to_utf8_json_escape_unit.sv */
`default_nettype none

// UTF-16 to UTF-8 converter with JSON string escaping.
// The input channel carries one UTF-16 code unit per transfer together with a
// flag that marks the last unit of a string. The output channel carries one
// escaped UTF-8 byte per transfer; run_last marks the last byte caused by one
// input unit and string_end the last byte of the string.
// A unit is taken into an input register, encoded combinationally into a
// buffer of up to nine bytes, and the buffer then sends one byte per cycle
// while the receiver is ready. The first byte of a unit is offered once the
// unit has passed the input register and been loaded into the buffer, which
// waits while the buffer is still busy with an earlier run. The buffer sets
// the pace: a unit yields one to three bytes for ordinary text, up to nine
// when a held high surrogate is dropped ahead of a control escape, and none
// for a high surrogate that is only held. A new unit is accepted while
// the buffer still sends the last byte of the previous one.
// When the receiver stalls, the buffer holds its byte and the input register
// fills; ready then falls until the buffer can take the next run.
// Reset empties both registers and drops any held high surrogate.
module utf16_to_utf8_json_escape_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    u2j_unit_if.sink   i_unit,
    u2j_byte_if.source o_byte
);

    // Input register.
    logic            r_in_v;
    logic            n_in_v;
    logic [15:0]     r_in_unit;
    logic            r_in_last;

    // High surrogate waiting for its partner.
    u2j_pkg::t_surr  r_surr;
    u2j_pkg::t_surr  n_surr;

    u2j_pkg::t_enc   enc;
    u2j_pkg::t_surr  enc_surr;
    logic            can_load;
    logic            adv;
    logic            load;
    logic            in_take;

    u2j_encoder u_enc (
        .i_unit (r_in_unit),
        .i_last (r_in_last),
        .i_surr (r_surr),
        .o_enc  (enc),
        .o_surr (enc_surr)
    );

    u2j_serializer u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_enc      (enc),
        .o_can_load (can_load),
        .o_byte     (o_byte)
    );

    // A unit that yields no bytes leaves the input register without
    // waiting for the buffer.
    assign adv     = r_in_v && ((enc.count == '0) || can_load);
    assign load    = r_in_v && (enc.count != '0) && can_load;
    assign in_take = i_unit.valid && i_unit.ready;

    assign i_unit.ready = !r_in_v || adv;

    always_comb begin
        n_in_v = r_in_v;
        n_surr = r_surr;
        if (adv) begin
            n_surr = enc_surr;
            n_in_v = 1'b0;
        end
        if (in_take) begin
            n_in_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_surr <= '0;
        end else begin
            r_in_v <= n_in_v;
            r_surr <= n_surr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_unit <= i_unit.code_unit;
            r_in_last <= i_unit.string_last;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> !r_surr.pend)
        else $error("surrogate held past the end of a string");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_byte.valid)
        else $error("loaded run not offered on the output");
    a_end_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && r_in_last) |-> (enc.count != '0))
        else $error("last unit of a string produced no bytes");
`endif

endmodule

`default_nettype wire
